// ===== rtl/spm_pkg.sv =====
// spm_pkg: shared types and fixed constants of the sparse polynomial multiplier
// used by spm_front, spm_back, spm_outq and sparse_polynomial_multiplier; no dependencies

package spm_pkg;

	localparam int EXP_W      = 10;
	localparam int PEXP_W     = 11;
	localparam int COEF_W     = 32;
	localparam int COUNT_W    = 7;
	localparam int SUM_W      = 39;
	localparam int STORE_DEPTH = 2 ** PEXP_W;

	localparam int FQ_DEPTH = 4;
	localparam int FQ_AW    = 2;
	localparam int FQ_CW    = 3;

	localparam int OQ_DEPTH = 2;
	localparam int OQ_AW    = 1;
	localparam int OQ_CW    = 2;

	localparam logic [1:0] CMD_LOAD_FIRST  = 2'd0;
	localparam logic [1:0] CMD_LOAD_SECOND = 2'd1;
	localparam logic [1:0] CMD_MULTIPLY    = 2'd2;

	typedef enum logic [1:0] {
		OP_LOAD_A = 2'd0,
		OP_LOAD_B = 2'd1,
		OP_MUL    = 2'd2
	} op_t;

	typedef struct packed {
		logic [1:0]               command;
		logic [EXP_W-1:0]         term_exponent;
		logic signed [COEF_W-1:0] term_coefficient;
	} in_t;

	typedef struct packed {
		logic [PEXP_W-1:0]        product_exponent;
		logic signed [COEF_W-1:0] product_coefficient;
		logic [COUNT_W-1:0]       term_count;
		logic                     is_empty;
		logic                     last_term;
	} out_t;

	typedef struct packed {
		op_t                      op;
		logic [EXP_W-1:0]         exponent;
		logic signed [COEF_W-1:0] coefficient;
	} cmd_t;

endpackage

// ===== rtl/spm_front.sv =====
// spm_front: input side, accepts transactions, clips exponents, drops unused commands
// and queues the rest for the back end; depends on spm_pkg

module spm_front #(
	parameter int EXP_MAX = 1023
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic         hold,
	output logic         full,
	input  spm_pkg::in_t term,
	output logic         q_valid,
	input  logic         q_pop,
	output spm_pkg::cmd_t q_item
);

	spm_pkg::cmd_t                 fifo_q [spm_pkg::FQ_DEPTH];
	logic [spm_pkg::FQ_AW-1:0]     wr_q;
	logic [spm_pkg::FQ_AW-1:0]     rd_q;
	logic [spm_pkg::FQ_CW-1:0]     cnt_q;
	logic                          accept;
	logic                          wr_en;
	logic                          rd_en;
	spm_pkg::cmd_t                 item;

	assign full    = (cnt_q == spm_pkg::FQ_CW'(spm_pkg::FQ_DEPTH)) | hold;
	assign accept  = push & ~full;
	assign q_valid = (cnt_q != '0);
	assign rd_en   = q_pop & q_valid;
	assign q_item  = fifo_q[rd_q];

	// classify
	always_comb begin
		item.exponent    = term.term_exponent;
		item.coefficient = term.term_coefficient;
		item.op          = spm_pkg::OP_MUL;
		wr_en            = accept;
		if (32'(term.term_exponent) > EXP_MAX) begin
			item.exponent = spm_pkg::EXP_W'(EXP_MAX);
		end
		unique case (term.command)
			spm_pkg::CMD_LOAD_FIRST:  item.op = spm_pkg::OP_LOAD_A;
			spm_pkg::CMD_LOAD_SECOND: item.op = spm_pkg::OP_LOAD_B;
			spm_pkg::CMD_MULTIPLY:    item.op = spm_pkg::OP_MUL;
			default:                  wr_en   = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wr_q <= wr_q + 1'b1;
			if (rd_en) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + spm_pkg::FQ_CW'(wr_en) - spm_pkg::FQ_CW'(rd_en);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) fifo_q[wr_q] <= item;
	end

endmodule

// ===== rtl/spm_back.sv =====
// spm_back: term storage, pairwise multiply-accumulate into the exponent-indexed store
// and the descending sweeps that count and emit terms; depends on spm_pkg

module spm_back #(
	parameter int MAX_TERMS      = 8,
	parameter int COEF_FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  spm_pkg::cmd_t cmd,
	output logic          cmd_pop,
	input  logic          res_full,
	output logic          res_push,
	output spm_pkg::out_t res,
	output logic          clearing
);

	localparam int IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int CW = $clog2(MAX_TERMS + 1);
	localparam int AW = spm_pkg::PEXP_W;
	localparam int SW = spm_pkg::SUM_W;

	typedef enum logic [9:0] {
		ST_CLEAR   = 10'b0000000001,
		ST_IDLE    = 10'b0000000010,
		ST_MUL     = 10'b0000000100,
		ST_RD      = 10'b0000001000,
		ST_ACC     = 10'b0000010000,
		ST_CNT_RD  = 10'b0000100000,
		ST_CNT_CHK = 10'b0001000000,
		ST_EM_RD   = 10'b0010000000,
		ST_EM_CHK  = 10'b0100000000,
		ST_MARK    = 10'b1000000000
	} state_t;

	state_t                             state_q;
	logic [spm_pkg::EXP_W-1:0]          a_exp_q  [MAX_TERMS];
	logic signed [spm_pkg::COEF_W-1:0]  a_coef_q [MAX_TERMS];
	logic [spm_pkg::EXP_W-1:0]          b_exp_q  [MAX_TERMS];
	logic signed [spm_pkg::COEF_W-1:0]  b_coef_q [MAX_TERMS];
	logic [CW-1:0]                      a_cnt_q;
	logic [CW-1:0]                      b_cnt_q;
	logic [IW-1:0]                      i_q;
	logic [IW-1:0]                      j_q;
	logic [AW-1:0]                      pe_q;
	logic signed [2*spm_pkg::COEF_W-1:0] prod_q;
	logic signed [spm_pkg::COEF_W-1:0]  pc_q;
	logic signed [SW-1:0]               mem_q [spm_pkg::STORE_DEPTH];
	logic signed [SW-1:0]               rd_q;
	logic [AW-1:0]                      addr_q;
	logic [spm_pkg::COUNT_W-1:0]        live_q;
	logic [spm_pkg::COUNT_W-1:0]        sent_q;

	logic                               ld_a;
	logic                               ld_b;
	logic                               i_last;
	logic                               j_last;
	logic                               mem_we;
	logic [AW-1:0]                      mem_wa;
	logic signed [SW-1:0]               mem_wd;
	logic [AW-1:0]                      mem_ra;
	logic signed [2*spm_pkg::COEF_W-1:0] shifted;
	logic [spm_pkg::COUNT_W-1:0]        live_nx;
	logic                               nz;

	function automatic logic signed [spm_pkg::COEF_W-1:0] sat_prod(
		input logic signed [2*spm_pkg::COEF_W-1:0] v);
		logic hi_same;
		hi_same = (v[2*spm_pkg::COEF_W-1:spm_pkg::COEF_W-1] == '0) ||
			(v[2*spm_pkg::COEF_W-1:spm_pkg::COEF_W-1] == '1);
		if (hi_same) return v[spm_pkg::COEF_W-1:0];
		return v[2*spm_pkg::COEF_W-1] ? {1'b1, {(spm_pkg::COEF_W-1){1'b0}}}
			: {1'b0, {(spm_pkg::COEF_W-1){1'b1}}};
	endfunction

	function automatic logic signed [spm_pkg::COEF_W-1:0] sat_sum(
		input logic signed [SW-1:0] v);
		logic hi_same;
		hi_same = (v[SW-1:spm_pkg::COEF_W-1] == '0) || (v[SW-1:spm_pkg::COEF_W-1] == '1);
		if (hi_same) return v[spm_pkg::COEF_W-1:0];
		return v[SW-1] ? {1'b1, {(spm_pkg::COEF_W-1){1'b0}}}
			: {1'b0, {(spm_pkg::COEF_W-1){1'b1}}};
	endfunction

	assign clearing = (state_q == ST_CLEAR);
	assign cmd_pop  = (state_q == ST_IDLE) && cmd_valid;
	assign ld_a     = cmd_pop && (cmd.op == spm_pkg::OP_LOAD_A) &&
		(a_cnt_q < CW'(MAX_TERMS));
	assign ld_b     = cmd_pop && (cmd.op == spm_pkg::OP_LOAD_B) &&
		(b_cnt_q < CW'(MAX_TERMS));
	assign i_last   = (CW'(i_q) + CW'(1)) == a_cnt_q;
	assign j_last   = (CW'(j_q) + CW'(1)) == b_cnt_q;
	assign shifted  = prod_q >>> COEF_FRAC_BITS;
	assign nz       = (rd_q != '0);
	assign live_nx  = live_q + spm_pkg::COUNT_W'(nz);

	// store port control and result
	always_comb begin
		mem_we   = 1'b0;
		mem_wa   = addr_q;
		mem_wd   = '0;
		mem_ra   = (state_q == ST_RD) ? pe_q : addr_q;
		res_push = 1'b0;
		res      = '0;
		unique case (state_q)
			ST_CLEAR: mem_we = 1'b1;
			ST_ACC: begin
				mem_we = 1'b1;
				mem_wa = pe_q;
				mem_wd = rd_q + SW'(pc_q);
			end
			ST_EM_CHK: begin
				res.product_exponent    = addr_q;
				res.product_coefficient = sat_sum(rd_q);
				res.term_count          = live_q;
				res.last_term           = (sent_q + 1'b1) == live_q;
				res_push                = nz && !res_full;
				mem_we                  = nz && !res_full;
			end
			ST_MARK: begin
				res.is_empty  = 1'b1;
				res.last_term = 1'b1;
				res_push      = !res_full;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_wa] <= mem_wd;
		rd_q <= mem_q[mem_ra];
	end

	always_ff @(posedge clk) begin
		if (ld_a) begin
			a_exp_q[a_cnt_q[IW-1:0]]  <= cmd.exponent;
			a_coef_q[a_cnt_q[IW-1:0]] <= cmd.coefficient;
		end
		if (ld_b) begin
			b_exp_q[b_cnt_q[IW-1:0]]  <= cmd.exponent;
			b_coef_q[b_cnt_q[IW-1:0]] <= cmd.coefficient;
		end
		if (state_q == ST_MUL) begin
			prod_q <= a_coef_q[i_q] * b_coef_q[j_q];
			pe_q   <= AW'(a_exp_q[i_q]) + AW'(b_exp_q[j_q]);
		end
		if (state_q == ST_RD) pc_q <= sat_prod(shifted);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			a_cnt_q <= '0;
			b_cnt_q <= '0;
			i_q     <= '0;
			j_q     <= '0;
			addr_q  <= '1;
			live_q  <= '0;
			sent_q  <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					addr_q <= addr_q - 1'b1;
					if (addr_q == '0) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (ld_a) a_cnt_q <= a_cnt_q + 1'b1;
					if (ld_b) b_cnt_q <= b_cnt_q + 1'b1;
					if (cmd_pop && cmd.op == spm_pkg::OP_MUL) begin
						i_q <= '0;
						j_q <= '0;
						if (a_cnt_q == '0 || b_cnt_q == '0) begin
							a_cnt_q <= '0;
							b_cnt_q <= '0;
							state_q <= ST_MARK;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: state_q <= ST_RD;
				ST_RD:  state_q <= ST_ACC;
				ST_ACC: begin
					if (j_last) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
					end else begin
						j_q <= j_q + 1'b1;
					end
					if (j_last && i_last) begin
						a_cnt_q <= '0;
						b_cnt_q <= '0;
						addr_q  <= '1;
						live_q  <= '0;
						state_q <= ST_CNT_RD;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_CNT_RD: state_q <= ST_CNT_CHK;
				ST_CNT_CHK: begin
					live_q <= live_nx;
					if (addr_q == '0) begin
						addr_q  <= '1;
						sent_q  <= '0;
						state_q <= (live_nx == '0) ? ST_MARK : ST_EM_RD;
					end else begin
						addr_q  <= addr_q - 1'b1;
						state_q <= ST_CNT_RD;
					end
				end
				ST_EM_RD: state_q <= ST_EM_CHK;
				ST_EM_CHK: begin
					if (!nz || !res_full) begin
						if (nz) sent_q <= sent_q + 1'b1;
						if ((nz && res.last_term) || addr_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							addr_q  <= addr_q - 1'b1;
							state_q <= ST_EM_RD;
						end
					end
				end
				ST_MARK: begin
					if (!res_full) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/spm_outq.sv =====
// spm_outq: two-entry result queue between the back end and the result ports
// depends on spm_pkg

module spm_outq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_push,
	input  spm_pkg::out_t in_item,
	output logic          in_full,
	output logic          empty,
	input  logic          pop,
	output spm_pkg::out_t result
);

	spm_pkg::out_t             fifo_q [spm_pkg::OQ_DEPTH];
	logic [spm_pkg::OQ_AW-1:0] wr_q;
	logic [spm_pkg::OQ_AW-1:0] rd_q;
	logic [spm_pkg::OQ_CW-1:0] cnt_q;
	logic                      wr_en;
	logic                      rd_en;

	assign in_full = (cnt_q == spm_pkg::OQ_CW'(spm_pkg::OQ_DEPTH));
	assign empty   = (cnt_q == '0);
	assign wr_en   = in_push & ~in_full;
	assign rd_en   = pop & ~empty;
	assign result  = fifo_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wr_q <= wr_q + 1'b1;
			if (rd_en) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + spm_pkg::OQ_CW'(wr_en) - spm_pkg::OQ_CW'(rd_en);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) fifo_q[wr_q] <= in_item;
	end

endmodule

// ===== rtl/sparse_polynomial_multiplier.sv =====
// sparse_polynomial_multiplier: top level, front queue, back end and result queue
// depends on spm_pkg, spm_front, spm_back, spm_outq
//
// channel   direction  handshake       payload
// term      in         push / full     spm_pkg::in_t
// result    out        pop / empty     spm_pkg::out_t
//
// an idle back end stores each term load as it pops it, and loads can follow every cycle
// a multiply runs the multiplier, store read and accumulate write steps per term pair,
// then a count sweep that reads and checks every store address and an emit sweep that
// reads and checks addresses from the top until the last term is sent
// after reset the whole 2048-entry store is cleared, full stays high meanwhile
// a stalled result side holds the emit sweep; the input queue takes transactions until full

module sparse_polynomial_multiplier #(
	parameter int MAX_TERMS      = 8,
	parameter int EXP_MAX        = 1023,
	parameter int COEF_FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  spm_pkg::in_t  term,
	output logic          empty,
	input  logic          pop,
	output spm_pkg::out_t result
);

	logic          clearing;
	logic          q_valid;
	logic          q_pop;
	spm_pkg::cmd_t q_item;
	logic          res_push;
	logic          res_full;
	spm_pkg::out_t res_item;

	spm_front #(
		.EXP_MAX(EXP_MAX)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.hold   (clearing),
		.full   (full),
		.term   (term),
		.q_valid(q_valid),
		.q_pop  (q_pop),
		.q_item (q_item)
	);

	spm_back #(
		.MAX_TERMS     (MAX_TERMS),
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(q_valid),
		.cmd      (q_item),
		.cmd_pop  (q_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res_item),
		.clearing (clearing)
	);

	spm_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.in_push(res_push),
		.in_item(res_item),
		.in_full(res_full),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> full)
		else $error("transaction accepted during store clear");

	a_marker_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.is_empty) |-> (result.last_term && result.term_count == '0 &&
		result.product_coefficient == '0))
		else $error("malformed empty marker");

	a_term_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.is_empty) |-> (result.product_coefficient != '0 &&
		result.term_count != '0))
		else $error("zero term emitted");

endmodule
